### hw/rtl/one_shot_timer_bank_assert.svh
// Assertion macros for the timer bank.
// Both sample on the rising edge of clk; the first is muted during reset.
`ifndef ONE_SHOT_TIMER_BANK_ASSERT_SVH
`define ONE_SHOT_TIMER_BANK_ASSERT_SVH

// Checked only while out of reset
`define OSTB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define OSTB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ostb_pkg.sv
`default_nettype none

package ostb_pkg;

	// Default bank shape
	localparam int OSTB_TIMER_COUNT  = 8;
	localparam int OSTB_COUNTER_BITS = 32;

	// Operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_UPDATE   = 3'd1;
	localparam logic [2:0] OP_TRIGGER  = 3'd2;
	localparam logic [2:0] OP_RESET    = 3'd3;
	localparam logic [2:0] OP_LEVEL    = 3'd4;
	localparam logic [2:0] OP_PRELOAD  = 3'd5;

	// Command item
	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  timer_index;
		logic [31:0] write_value;
	} ostb_cmd_t;

	// Result item
	typedef struct packed {
		logic [7:0] timer_outputs;
		logic [7:0] timers_running;
	} ostb_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/one_shot_timer_bank.sv
`default_nettype none
// Channel   Ports                 Handshake
// -------   -------------------   ----------------------------------------
// command   start, busy, item     taken on an edge with start high, busy low
// result    done, result          valid for the single cycle done is high
//
// Tick and update walk the bank through one shared decrement/compare unit,
// one timer per cycle in the sweep state, then report the result.
// Trigger, reset, level, preload and unused opcodes go from accept straight to the result, with no sweep.
// busy is high from the cycle after accept through the result cycle.
// arst_n clears all state but the counters; the receiver cannot stall results.
`include "one_shot_timer_bank_assert.svh"

module one_shot_timer_bank #(
	parameter int TIMER_COUNT  = ostb_pkg::OSTB_TIMER_COUNT,
	parameter int COUNTER_BITS = ostb_pkg::OSTB_COUNTER_BITS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire ostb_pkg::ostb_cmd_t item,
	output logic                done,
	output ostb_pkg::ostb_rsp_t result
);
	import ostb_pkg::*;

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int VIS   = (TIMER_COUNT < 8) ? TIMER_COUNT : 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
	localparam logic [5:0] TC_V = 6'(TIMER_COUNT);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;

	logic [1:0]              state_q;
	logic [IDX_W-1:0]        sweep_q;
	logic                    tick_q;
	logic [COUNTER_BITS-1:0] cnt_q  [TIMER_COUNT];
	logic [COUNTER_BITS-1:0] pre_q  [TIMER_COUNT];
	logic [TIMER_COUNT-1:0]  run_q;
	logic [TIMER_COUNT-1:0]  rstp_q;
	logic [TIMER_COUNT-1:0]  trgp_q;
	logic [TIMER_COUNT-1:0]  lvl_q;
	logic [TIMER_COUNT-1:0]  out_q;

	logic                    accept;
	logic                    is_sweep_op;
	logic                    idx_ok;
	logic [TIMER_COUNT-1:0]  sel;
	logic [TIMER_COUNT-1:0]  wr_trg;
	logic [TIMER_COUNT-1:0]  wr_rst;
	logic [TIMER_COUNT-1:0]  wr_lvl;
	logic [TIMER_COUNT-1:0]  wr_pre;

	// Shared unit signals
	logic                    sweeping;
	logic [COUNTER_BITS-1:0] cnt_rd;
	logic [COUNTER_BITS-1:0] cnt_new;
	logic                    cnt_wr;
	logic                    run_new;
	logic                    clr_req;
	logic                    out_wr;
	logic                    out_new;

	assign accept      = start && !busy;
	assign is_sweep_op = (item.opcode == OP_TICK) || (item.opcode == OP_UPDATE);
	assign idx_ok      = {3'b000, item.timer_index} < TC_V;
	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_REPORT);
	assign sweeping    = (state_q == ST_SWEEP);

	// Timer select decode for single-timer operations
	always_comb begin
		for (int i = 0; i < TIMER_COUNT; i++) begin
			sel[i] = accept && idx_ok && ({3'b000, item.timer_index} == 6'(i));
		end
		wr_trg = (item.opcode == OP_TRIGGER) ? sel : '0;
		wr_rst = (item.opcode == OP_RESET)   ? sel : '0;
		wr_lvl = (item.opcode == OP_LEVEL)   ? sel : '0;
		wr_pre = (item.opcode == OP_PRELOAD) ? sel : '0;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sweep_q <= '0;
			tick_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sweep_q <= '0;
						tick_q  <= (item.opcode == OP_TICK);
						state_q <= is_sweep_op ? ST_SWEEP : ST_REPORT;
					end
				end
				ST_SWEEP: begin
					if (sweep_q == LAST_IDX) begin
						state_q <= ST_REPORT;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Shared per-timer unit: decrement, load or clear, then zero compare
	assign cnt_rd = cnt_q[sweep_q];
	always_comb begin
		cnt_new = cnt_rd;
		cnt_wr  = 1'b0;
		clr_req = 1'b0;
		out_wr  = 1'b0;
		out_new = lvl_q[sweep_q];
		if (tick_q) begin
			if (run_q[sweep_q]) begin
				cnt_new = cnt_rd - 1'b1;
				cnt_wr  = 1'b1;
			end
		end else if (rstp_q[sweep_q]) begin
			cnt_new = '0;
			cnt_wr  = 1'b1;
			clr_req = 1'b1;
			out_wr  = 1'b1;
		end else if (trgp_q[sweep_q]) begin
			cnt_new = pre_q[sweep_q];
			cnt_wr  = 1'b1;
			clr_req = 1'b1;
			out_wr  = 1'b1;
			out_new = ~lvl_q[sweep_q];
		end else if (!run_q[sweep_q]) begin
			out_wr  = 1'b1;
		end
		run_new = (cnt_new != '0);
	end

	// Counter store
	always_ff @(posedge clk) begin
		if (sweeping && cnt_wr) begin
			cnt_q[sweep_q] <= cnt_new;
		end
	end

	// Preload store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				pre_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				if (wr_pre[i]) begin
					pre_q[i] <= COUNTER_BITS'(item.write_value);
				end
			end
		end
	end

	// Per-timer flags; running bit mirrors counter != 0 (counters start unknown,
	// so a stopped counter is only ever read while its running bit is clear)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			rstp_q <= '0;
			trgp_q <= '0;
			lvl_q  <= '0;
			out_q  <= '0;
		end else if (sweeping) begin
			if (cnt_wr) begin
				run_q[sweep_q] <= run_new;
			end
			if (clr_req) begin
				rstp_q[sweep_q] <= 1'b0;
				trgp_q[sweep_q] <= 1'b0;
			end
			if (out_wr) begin
				out_q[sweep_q] <= out_new;
			end
		end else begin
			rstp_q <= rstp_q | wr_rst;
			trgp_q <= trgp_q | wr_trg;
			lvl_q  <= (lvl_q & ~wr_lvl) | (wr_lvl & {TIMER_COUNT{item.write_value[0]}});
		end
	end

	// Result view of the first eight timers
	assign result.timer_outputs  = 8'(out_q[VIS-1:0]);
	assign result.timers_running = 8'(run_q[VIS-1:0]);

	// Checks
	`OSTB_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
	`OSTB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
	`OSTB_ASSERT(a_sweep_range, sweeping |-> (sweep_q <= LAST_IDX), "sweep index past last timer")
	`OSTB_ASSERT_ALWAYS(a_done_busy, done |-> busy, "result strobe outside busy window")

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ostb_pkg::*;

	localparam int TIMERS = OSTB_TIMER_COUNT;
	localparam int CBITS = OSTB_COUNTER_BITS;
	// Opcodes the bank does not define
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	// Drain wait: a tick/update sweep of the bank plus margin
	localparam int DRAIN_CYCLES = OSTB_TIMER_COUNT + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	ostb_cmd_t cmd = '0;
	logic busy;
	logic done;
	ostb_rsp_t rsp;

	one_shot_timer_bank i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(cmd),
		.done(done),
		.result(rsp)
	);

	always #1 clk = ~clk;

	// Shadow copy of the timer bank
	logic [CBITS-1:0] counter_q [TIMERS];
	logic [CBITS-1:0] preload_q [TIMERS];
	logic [TIMERS-1:0] reset_req = '0;
	logic [TIMERS-1:0] trigger_req = '0;
	logic [TIMERS-1:0] level_q = '0;
	logic [TIMERS-1:0] out_q = '0;

	ostb_rsp_t expected_outputs [$];
	ostb_rsp_t want_rsp;
	int error_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	int expiries = 0;
	int op_count [8];
	int cycle_count = 0;
	bit gaps_enabled = 1'b1;

	initial begin
		for (int i = 0; i < TIMERS; i++) begin
			counter_q[i] = '0;
			preload_q[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			op_count[i] = 0;
	end

	// Apply one item to the shadow bank and return the outputs it leaves
	function automatic ostb_rsp_t advance_bank(ostb_cmd_t c);
		ostb_rsp_t r;
		case (c.opcode)
			OP_TICK: begin
				for (int i = 0; i < TIMERS; i++)
					if (counter_q[i] != '0) begin
						counter_q[i] = counter_q[i] - 1'b1;
						if (counter_q[i] == '0)
							expiries++;
					end
			end
			OP_UPDATE: begin
				for (int i = 0; i < TIMERS; i++)
					if (reset_req[i]) begin
						reset_req[i] = 1'b0;
						trigger_req[i] = 1'b0;
						out_q[i] = level_q[i];
						counter_q[i] = '0;
					end else if (trigger_req[i]) begin
						trigger_req[i] = 1'b0;
						out_q[i] = ~level_q[i];
						counter_q[i] = preload_q[i];
					end else if (counter_q[i] == '0) begin
						out_q[i] = level_q[i];
					end
			end
			OP_TRIGGER: if (c.timer_index < TIMERS) trigger_req[c.timer_index] = 1'b1;
			OP_RESET:   if (c.timer_index < TIMERS) reset_req[c.timer_index] = 1'b1;
			OP_LEVEL:   if (c.timer_index < TIMERS) level_q[c.timer_index] = c.write_value[0];
			OP_PRELOAD: begin
				if (c.timer_index < TIMERS)
					preload_q[c.timer_index] = c.write_value[CBITS-1:0];
			end
			default: ;
		endcase
		r = '0;
		for (int i = 0; i < TIMERS && i < 8; i++) begin
			r.timer_outputs[i] = out_q[i];
			r.timers_running[i] = (counter_q[i] != '0);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("ERROR @%0t: %s: got %02h, expected %02h", $realtime, what, got, want);
		error_count++;
	endtask

	// Send one item; wait for acceptance, then record its expected outputs
	task automatic send_cmd(input logic [2:0] op, input logic [2:0] idx,
			input logic [31:0] val);
		ostb_cmd_t c;
		c.opcode = op;
		c.timer_index = idx;
		c.write_value = val;
		if (gaps_enabled && $urandom_range(99) < 23) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		expected_outputs.push_back(advance_bank(c));
		op_count[op]++;
		items_sent++;
	endtask

	// Mix that keeps timers cycling: small preloads so they run out under ticks
	task automatic send_random_timer_op();
		int pick;
		logic [31:0] v;
		pick = $urandom_range(99);
		v = $urandom;
		if (pick < 34)
			send_cmd(OP_TICK, 3'($urandom_range(7)), v);
		else if (pick < 52)
			send_cmd(OP_UPDATE, 3'($urandom_range(7)), v);
		else if (pick < 64)
			send_cmd(OP_TRIGGER, 3'($urandom_range(7)), v);
		else if (pick < 70)
			send_cmd(OP_RESET, 3'($urandom_range(7)), v);
		else if (pick < 78)
			send_cmd(OP_LEVEL, 3'($urandom_range(7)), v);
		else if (pick < 93) begin
			// mostly short counts, now and then a full-width one
			if ($urandom_range(19) != 0)
				v = $urandom_range(12);
			send_cmd(OP_PRELOAD, 3'($urandom_range(7)), v);
		end else
			send_cmd($urandom_range(1) ? OP_SPARE7 : OP_SPARE6, 3'($urandom_range(7)), v);
	endtask

	// Corner cases one by one
	task automatic test_directed();
		// short one-shot on timer 0, level low with upper value bits set
		send_cmd(OP_PRELOAD, 3'd0, 32'd3);
		send_cmd(OP_LEVEL, 3'd0, 32'hFFFF_FFFE);
		send_cmd(OP_TRIGGER, 3'd0, 32'h0);
		send_cmd(OP_UPDATE, 3'd0, 32'hFFFF_FFFF);
		repeat (3) send_cmd(OP_TICK, 3'd0, 32'h0);
		// tick on a stopped timer
		send_cmd(OP_TICK, 3'd7, 32'hFFFF_FFFF);
		send_cmd(OP_UPDATE, 3'd0, 32'h0);
		// high idle level on the last timer, max preload
		send_cmd(OP_LEVEL, 3'd7, 32'h0000_0001);
		send_cmd(OP_UPDATE, 3'd7, 32'h0);
		send_cmd(OP_PRELOAD, 3'd7, 32'hFFFF_FFFF);
		send_cmd(OP_TRIGGER, 3'd7, 32'h0);
		send_cmd(OP_UPDATE, 3'd7, 32'h0);
		send_cmd(OP_TICK, 3'd7, 32'h0);
		// reset and trigger pending together: reset wins
		send_cmd(OP_RESET, 3'd7, 32'h0);
		send_cmd(OP_TRIGGER, 3'd7, 32'h0);
		send_cmd(OP_UPDATE, 3'd7, 32'h0);
		// zero preload: output flips for one update only
		send_cmd(OP_PRELOAD, 3'd1, 32'h0);
		send_cmd(OP_TRIGGER, 3'd1, 32'h0);
		send_cmd(OP_UPDATE, 3'd1, 32'h0);
		send_cmd(OP_UPDATE, 3'd1, 32'h0);
		// undefined opcodes leave everything alone
		send_cmd(OP_SPARE6, 3'd5, 32'hA5A5_5A5A);
		send_cmd(OP_SPARE7, 3'd2, 32'h5A5A_A5A5);
		send_cmd(OP_LEVEL, 3'd7, 32'h0);
		send_cmd(OP_UPDATE, 3'd0, 32'h0);
	endtask

	task automatic test_timer_sequences(input int n);
		repeat (n) send_random_timer_op();
	endtask

	// Same mix with start held high between items
	task automatic test_back_to_back(input int n);
		gaps_enabled = 1'b0;
		repeat (n) send_random_timer_op();
		gaps_enabled = 1'b1;
	endtask

	// Fully random fields
	task automatic test_noise(input int n);
		repeat (n) send_cmd(3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch("unexpected result, outputs", rsp.timer_outputs, 8'h00);
			end else begin
				want_rsp = expected_outputs.pop_front();
				results_checked++;
				if (rsp.timer_outputs !== want_rsp.timer_outputs)
					report_mismatch("timer_outputs", rsp.timer_outputs,
						want_rsp.timer_outputs);
				if (rsp.timers_running !== want_rsp.timers_running)
					report_mismatch("timers_running", rsp.timers_running,
						want_rsp.timers_running);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_outputs.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_timer_sequences(950);
		test_back_to_back(300);
		test_noise(150);
		drain();

		$display("Ran %0d items: %0d ticks, %0d updates, %0d triggers, %0d resets",
			items_sent, op_count[OP_TICK], op_count[OP_UPDATE], op_count[OP_TRIGGER],
			op_count[OP_RESET]);
		$display("%0d results checked, %0d timer expiries seen, %0d mismatches",
			results_checked, expiries, error_count);
		if (error_count == 0 && expected_outputs.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ostb_pkg.sv
hw/rtl/one_shot_timer_bank.sv
test/tb_top.sv
